// ===== src/tmp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package tmp_pkg;

	localparam int MUL_W = 34;

	localparam logic [31:0] U32_MAX = 32'hffff_ffff;
	localparam logic [31:0] S32_MAX = 32'h7fff_ffff;
	localparam logic [31:0] S32_MIN = 32'h8000_0000;

	localparam logic ACT_SET_GOAL = 1'b0;
	localparam logic ACT_UPDATE   = 1'b1;

	localparam logic REG_MAX_VELOCITY = 1'b0;
	localparam logic REG_RAMP_TIME    = 1'b1;

	typedef enum logic [4:0] {
		S_IDLE,
		S_ACC_DIV,
		S_ACC_WAIT,
		S_TR_DIV,
		S_TR_WAIT,
		S_CMP_MUL,
		S_CMP,
		S_TRI_DIV,
		S_TRI_WAIT,
		S_SQRT,
		S_SQRT_WAIT,
		S_PEAK_MUL,
		S_PEAK,
		S_CRU_DIV,
		S_CRU_WAIT,
		S_UPD_MUL,
		S_UPD_VEL,
		S_UPD_POS_MUL,
		S_UPD_POS,
		S_DONE
	} tmp_state_t;

	typedef enum logic [1:0] {
		RG_RAMP,
		RG_CRUISE,
		RG_DECEL,
		RG_STOP
	} tmp_region_t;

	typedef struct packed {
		logic start;
		logic is_sqrt;
	} ss_cmd_t;

endpackage
`default_nettype wire

// ===== src/tmp_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tmp_mul
	import tmp_pkg::*;
(
	input  wire logic                        clk,
	input  wire logic signed [MUL_W-1:0]     a,
	input  wire logic signed [MUL_W-1:0]     b,
	output logic signed [2*MUL_W-1:0]        p_q
);

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

endmodule
`default_nettype wire

// ===== src/tmp_shiftsub.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tmp_shiftsub
	import tmp_pkg::*;
#(
	parameter int SW = 65
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire ss_cmd_t       cmd,
	input  wire logic [SW-1:0] load_val,
	input  wire logic [31:0]   divisor,
	output logic               done_q,
	output logic [SW-1:0]      quo_q
);

	localparam int CW = $clog2(SW + 1);
	localparam logic [CW-1:0] DIV_STEPS  = CW'(SW);
	localparam logic [CW-1:0] SQRT_STEPS = CW'(32);

	logic          busy_q;
	logic          sqrt_q;
	logic [CW-1:0] cnt_q;
	logic [35:0]   rem_q;
	logic [SW-1:0] num_q;
	logic [31:0]   den_q;

	logic [35:0]   shifted;
	logic [35:0]   sub;
	logic [36:0]   diff;
	logic          ge;

	always_comb begin
		if (sqrt_q) begin
			shifted = {rem_q[33:0], num_q[SW-1:SW-2]};
			sub     = {1'b0, quo_q[32:0], 2'b01};
		end else begin
			shifted = {rem_q[34:0], num_q[SW-1]};
			sub     = {4'b0, den_q};
		end
		diff = {1'b0, shifted} - {1'b0, sub};
		ge   = ~diff[36];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= cmd.is_sqrt ? SQRT_STEPS : DIV_STEPS;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			sqrt_q <= cmd.is_sqrt;
			rem_q  <= '0;
			num_q  <= load_val;
			den_q  <= divisor;
			quo_q  <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[35:0] : shifted;
			quo_q <= {quo_q[SW-2:0], ge};
			num_q <= sqrt_q ? (num_q << 2) : (num_q << 1);
		end
	end

`ifndef NO_ASSERTIONS
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> !busy_q) else $error("start while busy");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("done while busy");
	a_busy_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !cmd.start) |=> (busy_q || done_q)) else $error("busy dropped without done");
`endif

endmodule
`default_nettype wire

// ===== src/trapezoid_motion_profile.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Trapezoidal velocity profile generator, fixed point with FRAC_BITS fraction bits. One item is
// worked at a time; item_ready is high only while the sequencer is idle. An update makes two
// passes through the shared 34x34 multiplier. A set-goal runs up to three divisions and one square
// root, one bit per cycle, through the single shift-subtract unit of SW = max(33+2*FRAC_BITS, 64)
// bits (65 at Q16.16). The result register lets the next item be taken while the previous result
// waits for result_ready.
module trapezoid_motion_profile
	import tmp_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [2:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	input  wire logic               item_valid,
	output logic                    item_ready,
	input  wire logic               action,
	input  wire logic [31:0]        time_now,
	input  wire logic signed [31:0] goal_displacement,
	input  wire logic signed [31:0] current_displacement,
	output logic                    result_valid,
	input  wire logic               result_ready,
	output logic signed [31:0]      out_displacement,
	output logic signed [31:0]      out_velocity,
	output logic signed [31:0]      out_acceleration
);

	localparam int NW = 33 + 2 * FRAC_BITS;
	localparam int SW = (NW > 64) ? NW : 64;
	localparam int PW = 2 * MUL_W;

	tmp_state_t state_q, state_d;

	logic [30:0]        max_velocity_q;
	logic [30:0]        ramp_time_q;
	logic               dir_neg_q;
	logic [31:0]        accel_rate_q;
	logic [31:0]        ramp_end_q;
	logic [31:0]        cruise_end_q;
	logic [31:0]        total_q;
	logic [30:0]        peak_q;
	logic [31:0]        prev_time_q;
	logic signed [31:0] setpoint_q;
	logic [32:0]        mag_q;
	logic [31:0]        time_q;
	logic signed [31:0] vel_q;
	logic signed [31:0] acc_q;

	ss_cmd_t            ss_cmd;
	logic [SW-1:0]      ss_load;
	logic [31:0]        ss_div;
	logic               ss_done;
	logic [SW-1:0]      ss_quo;

	logic signed [MUL_W-1:0] mul_a, mul_b;
	logic signed [PW-1:0]    mul_p;
	logic signed [PW-1:0]    shr;

	logic [127:0]       quo_x;
	logic [31:0]        quo_sat32;
	logic [63:0]        quo_sat64;
	logic [31:0]        accel_new;
	logic [32:0]        cru_total;
	logic [31:0]        sq_root;
	logic signed [32:0] disp_diff;
	logic signed [32:0] dt;
	logic signed [PW:0] pos_sum;
	logic [31:0]        pos_sat;
	tmp_region_t        region;
	logic [30:0]        vel_mag;
	logic [31:0]        acc_val;
	logic               acc_negate;
	logic               cfg_write;
	logic               load_result;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign prdata    = (paddr[2] == REG_RAMP_TIME) ? {1'b0, ramp_time_q} : {1'b0, max_velocity_q};

	tmp_shiftsub #(.SW(SW)) u_shiftsub (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (ss_cmd),
		.load_val (ss_load),
		.divisor  (ss_div),
		.done_q   (ss_done),
		.quo_q    (ss_quo)
	);

	tmp_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (mul_p)
	);

	always_comb begin
		quo_x     = 128'(ss_quo);
		quo_sat32 = (|quo_x[127:32]) ? U32_MAX : quo_x[31:0];
		quo_sat64 = (|quo_x[127:64]) ? 64'hffff_ffff_ffff_ffff : quo_x[63:0];
		accel_new = (max_velocity_q == '0) ? '0 : quo_sat32;
		cru_total = {1'b0, quo_sat32} + {1'b0, ramp_end_q};
		sq_root   = ss_quo[31:0];
		disp_diff = 33'(goal_displacement) - 33'(current_displacement);
		dt        = $signed({1'b0, time_q}) - $signed({1'b0, prev_time_q});
		shr       = mul_p >>> FRAC_BITS;
		pos_sum   = (PW + 1)'(setpoint_q) + (PW + 1)'(shr);
		if ((&pos_sum[PW:31]) || !(|pos_sum[PW:31]))
			pos_sat = pos_sum[31:0];
		else
			pos_sat = pos_sum[PW] ? S32_MIN : S32_MAX;
	end

	always_comb begin
		priority if (time_q < ramp_end_q)
			region = RG_RAMP;
		else if (time_q < cruise_end_q)
			region = RG_CRUISE;
		else if (time_q < total_q)
			region = RG_DECEL;
		else
			region = RG_STOP;
	end

	always_comb begin
		vel_mag    = '0;
		acc_negate = dir_neg_q;
		unique case (region)
			RG_RAMP: begin
				vel_mag = (|shr[PW-1:31]) ? S32_MAX[30:0] : shr[30:0];
			end
			RG_CRUISE: begin
				vel_mag = peak_q;
			end
			RG_DECEL: begin
				acc_negate = !dir_neg_q;
				if ((|shr[PW-1:31]) || (shr[30:0] >= peak_q))
					vel_mag = '0;
				else
					vel_mag = peak_q - shr[30:0];
			end
			RG_STOP: begin
				vel_mag = '0;
			end
			default: begin
				vel_mag = '0;
			end
		endcase
		if (region == RG_CRUISE || region == RG_STOP)
			acc_val = '0;
		else if (acc_negate)
			acc_val = (accel_rate_q > S32_MIN) ? S32_MIN : (~accel_rate_q + 32'd1);
		else
			acc_val = accel_rate_q[31] ? S32_MAX : accel_rate_q;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (item_valid)
					state_d = (action == ACT_SET_GOAL) ? S_ACC_DIV : S_UPD_MUL;
			end
			S_ACC_DIV:   state_d = S_ACC_WAIT;
			S_ACC_WAIT: begin
				if (ss_done)
					state_d = (accel_new == '0) ? S_DONE : S_TR_DIV;
			end
			S_TR_DIV:    state_d = S_TR_WAIT;
			S_TR_WAIT:   if (ss_done) state_d = S_CMP_MUL;
			S_CMP_MUL:   state_d = S_CMP;
			S_CMP: begin
				if ($unsigned(mul_p) > PW'({mag_q, {FRAC_BITS{1'b0}}}))
					state_d = S_TRI_DIV;
				else
					state_d = S_CRU_DIV;
			end
			S_TRI_DIV:   state_d = S_TRI_WAIT;
			S_TRI_WAIT:  if (ss_done) state_d = S_SQRT;
			S_SQRT:      state_d = S_SQRT_WAIT;
			S_SQRT_WAIT: if (ss_done) state_d = S_PEAK_MUL;
			S_PEAK_MUL:  state_d = S_PEAK;
			S_PEAK:      state_d = S_DONE;
			S_CRU_DIV:   state_d = S_CRU_WAIT;
			S_CRU_WAIT:  if (ss_done) state_d = S_DONE;
			S_UPD_MUL:   state_d = S_UPD_VEL;
			S_UPD_VEL:   state_d = S_UPD_POS_MUL;
			S_UPD_POS_MUL: state_d = S_UPD_POS;
			S_UPD_POS:   state_d = S_DONE;
			S_DONE:      if (!result_valid || result_ready) state_d = S_IDLE;
			default:     state_d = S_IDLE;
		endcase
	end

	always_comb begin
		item_ready  = 1'b0;
		load_result = 1'b0;
		ss_cmd      = '0;
		ss_load     = '0;
		ss_div      = '0;
		mul_a       = '0;
		mul_b       = '0;
		unique case (state_q)
			S_IDLE: item_ready = 1'b1;
			S_ACC_DIV: begin
				ss_cmd.start = 1'b1;
				ss_load      = SW'(max_velocity_q) << FRAC_BITS;
				ss_div       = {1'b0, ramp_time_q};
			end
			S_TR_DIV: begin
				ss_cmd.start = 1'b1;
				ss_load      = SW'(max_velocity_q) << FRAC_BITS;
				ss_div       = accel_rate_q;
			end
			S_CMP_MUL: begin
				mul_a = MUL_W'(max_velocity_q);
				mul_b = MUL_W'(ramp_end_q);
			end
			S_TRI_DIV: begin
				ss_cmd.start = 1'b1;
				ss_load      = SW'(mag_q) << (2 * FRAC_BITS);
				ss_div       = accel_rate_q;
			end
			S_SQRT: begin
				ss_cmd.start   = 1'b1;
				ss_cmd.is_sqrt = 1'b1;
				ss_load        = SW'(quo_sat64) << (SW - 64);
			end
			S_PEAK_MUL: begin
				mul_a = MUL_W'(accel_rate_q);
				mul_b = MUL_W'(ramp_end_q);
			end
			S_CRU_DIV: begin
				ss_cmd.start = 1'b1;
				ss_load      = SW'(mag_q) << FRAC_BITS;
				ss_div       = {1'b0, max_velocity_q};
			end
			S_UPD_MUL: begin
				mul_a = MUL_W'(accel_rate_q);
				if (region == RG_DECEL)
					mul_b = MUL_W'(time_q - cruise_end_q);
				else
					mul_b = MUL_W'(time_q);
			end
			S_UPD_POS_MUL: begin
				mul_a = MUL_W'(vel_q);
				mul_b = MUL_W'(dt);
			end
			S_DONE: load_result = !result_valid || result_ready;
			default: begin
				item_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			max_velocity_q <= 31'(1) << FRAC_BITS;
			ramp_time_q    <= 31'(1) << FRAC_BITS;
			dir_neg_q      <= 1'b0;
			accel_rate_q   <= '0;
			ramp_end_q     <= '0;
			cruise_end_q   <= '0;
			total_q        <= '0;
			peak_q         <= '0;
			prev_time_q    <= '0;
			setpoint_q     <= '0;
			result_valid   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_write) begin
				if (paddr[2] == REG_MAX_VELOCITY)
					max_velocity_q <= pwdata[30:0];
				else
					ramp_time_q <= pwdata[30:0];
			end
			if (load_result)
				result_valid <= 1'b1;
			else if (result_ready)
				result_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (item_valid && action == ACT_SET_GOAL) begin
						dir_neg_q   <= disp_diff[32];
						prev_time_q <= time_now;
						setpoint_q  <= current_displacement;
					end
				end
				S_ACC_WAIT: begin
					if (ss_done) begin
						accel_rate_q <= accel_new;
						if (accel_new == '0) begin
							ramp_end_q   <= U32_MAX;
							cruise_end_q <= U32_MAX;
							total_q      <= U32_MAX;
							peak_q       <= '0;
						end
					end
				end
				S_TR_WAIT: if (ss_done) ramp_end_q <= quo_sat32;
				S_SQRT_WAIT: begin
					if (ss_done) begin
						ramp_end_q   <= sq_root;
						cruise_end_q <= sq_root;
						total_q      <= sq_root[31] ? U32_MAX : {sq_root[30:0], 1'b0};
					end
				end
				S_PEAK: peak_q <= (|shr[PW-1:31]) ? S32_MAX[30:0] : shr[30:0];
				S_CRU_WAIT: begin
					if (ss_done) begin
						cruise_end_q <= quo_sat32;
						total_q      <= cru_total[32] ? U32_MAX : cru_total[31:0];
						peak_q       <= max_velocity_q;
					end
				end
				S_UPD_POS: begin
					setpoint_q  <= pos_sat;
					prev_time_q <= time_q;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && item_valid) begin
			time_q <= time_now;
			mag_q  <= disp_diff[32] ? 33'(-disp_diff) : 33'(disp_diff);
			vel_q  <= '0;
			acc_q  <= '0;
		end
		if (state_q == S_UPD_VEL) begin
			vel_q <= dir_neg_q ? -$signed({1'b0, vel_mag}) : $signed({1'b0, vel_mag});
			acc_q <= acc_val;
		end
		if (load_result) begin
			out_displacement <= setpoint_q;
			out_velocity     <= vel_q;
			out_acceleration <= acc_q;
		end
	end

endmodule
`default_nettype wire

// ===== dv/tb_trapezoid_motion_profile.sv =====
`timescale 1ns / 1ps
module tb_trapezoid_motion_profile;
	import tmp_pkg::*;

	localparam longint ONE = 64'd65536;
	localparam longint S32_HI = 64'sd2147483647;
	localparam longint S32_LO = -64'sd2147483648;
	localparam bit [63:0] U32_ALL = 64'hffff_ffff;
	localparam int CYCLE_LIMIT = 2000000;

	typedef struct {
		logic signed [31:0] disp;
		logic signed [31:0] vel;
		logic signed [31:0] acc;
	} setpoint_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic item_valid = 1'b0;
	logic item_ready;
	logic action = ACT_SET_GOAL;
	logic [31:0] time_now = '0;
	logic signed [31:0] goal_displacement = '0;
	logic signed [31:0] current_displacement = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	logic signed [31:0] out_displacement, out_velocity, out_acceleration;

	trapezoid_motion_profile DUT (.*);

	// profile state mirrored in the testbench
	bit [63:0] cfg_max_vel = ONE, cfg_ramp = ONE;
	bit moving_negative;
	bit [63:0] accel_q, ramp_end_q, cruise_end_q, total_q, peak_q, last_time_q;
	longint setpoint_q;

	setpoint_t setpoint_expect[$];
	int errors = 0;
	int cycles = 0;
	bit quiet = 1'b0;

	initial forever #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(negedge clk)
		result_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 7);

	function automatic bit [63:0] clip_u32(bit [63:0] v);
		return v > U32_ALL ? U32_ALL : v;
	endfunction

	function automatic longint clip_s32(longint v);
		if (v > S32_HI) return S32_HI;
		if (v < S32_LO) return S32_LO;
		return v;
	endfunction

	function automatic bit [63:0] floor_sqrt(bit [63:0] x);
		bit [63:0] res = 0;
		bit [63:0] b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic bit [63:0] div_q32(bit [63:0] num, bit [63:0] den);
		bit [63:0] n = num << 16;
		bit [63:0] q1 = n / den;
		bit [63:0] r1 = n % den;
		if (q1 > (64'hffff_ffff_ffff_ffff >> 16)) return 64'hffff_ffff_ffff_ffff;
		return (q1 << 16) + ((r1 << 16) / den);
	endfunction

	function automatic void plan_move(bit [63:0] mag);
		bit [63:0] v = cfg_max_vel;
		bit [63:0] a, t_ramp, t, cruise;
		if (cfg_ramp == 0) a = (v != 0) ? U32_ALL : 0;
		else a = clip_u32((v << 16) / cfg_ramp);
		accel_q = a;
		if (a == 0) begin
			ramp_end_q = U32_ALL;
			cruise_end_q = U32_ALL;
			total_q = U32_ALL;
			peak_q = 0;
			return;
		end
		t_ramp = clip_u32((v << 16) / a);
		if (v * t_ramp > (mag << 16)) begin
			t = clip_u32(floor_sqrt(div_q32(mag, a)));
			ramp_end_q = t;
			cruise_end_q = t;
			total_q = clip_u32(2 * t);
			peak_q = (a * t) >> 16;
			if (peak_q > 64'h7fff_ffff) peak_q = 64'h7fff_ffff;
		end else begin
			cruise = clip_u32((mag << 16) / v);
			ramp_end_q = t_ramp;
			cruise_end_q = cruise;
			total_q = clip_u32(cruise + t_ramp);
			peak_q = v;
		end
	endfunction

	function automatic setpoint_t profile_step(logic act, logic [31:0] tnow,
			logic signed [31:0] goal, logic signed [31:0] cur);
		setpoint_t r;
		bit [63:0] t = tnow;
		bit [63:0] vv, drop;
		longint disp_diff, acc, vel, dt, prod;
		if (act == ACT_SET_GOAL) begin
			disp_diff = longint'(goal) - longint'(cur);
			moving_negative = disp_diff < 0;
			plan_move(moving_negative ? -disp_diff : disp_diff);
			last_time_q = t;
			setpoint_q = cur;
			r.disp = cur;
			r.vel = 0;
			r.acc = 0;
			return r;
		end
		if (t < ramp_end_q) begin
			vv = (accel_q * t) >> 16;
			acc = accel_q;
			vel = vv > 64'h7fff_ffff ? S32_HI : longint'(vv);
		end else if (t < cruise_end_q) begin
			acc = 0;
			vel = peak_q;
		end else if (t < total_q) begin
			drop = (accel_q * (t - cruise_end_q)) >> 16;
			acc = -longint'(accel_q);
			vel = drop >= peak_q ? 0 : longint'(peak_q - drop);
		end else begin
			acc = 0;
			vel = 0;
		end
		if (moving_negative) begin
			acc = -acc;
			vel = -vel;
		end
		acc = clip_s32(acc);
		vel = clip_s32(vel);
		dt = longint'(t) - longint'(last_time_q);
		prod = vel * dt;
		setpoint_q = clip_s32(setpoint_q + (prod >>> 16));
		last_time_q = t;
		r.disp = setpoint_q;
		r.vel = vel;
		r.acc = acc;
		return r;
	endfunction

	always @(posedge clk) begin
		setpoint_t e;
		if (result_valid && result_ready) begin
			if (setpoint_expect.size() == 0) begin
				$error("result transfer with nothing expected");
				errors++;
			end else begin
				e = setpoint_expect.pop_front();
				if (out_displacement !== e.disp) begin
					$error("out_displacement expected %0d actual %0d", e.disp, out_displacement);
					errors++;
				end
				if (out_velocity !== e.vel) begin
					$error("out_velocity expected %0d actual %0d", e.vel, out_velocity);
					errors++;
				end
				if (out_acceleration !== e.acc) begin
					$error("out_acceleration expected %0d actual %0d", e.acc, out_acceleration);
					errors++;
				end
			end
		end
	end

	task automatic send_item(logic act, logic [31:0] tnow, logic signed [31:0] goal,
			logic signed [31:0] cur);
		while (!quiet && $urandom_range(99) < 7) begin
			item_valid = 1'b0;
			@(negedge clk);
		end
		item_valid = 1'b1;
		action = act;
		time_now = tnow;
		goal_displacement = goal;
		current_displacement = cur;
		do @(posedge clk); while (!item_ready);
		setpoint_expect.push_back(profile_step(act, tnow, goal, cur));
		@(negedge clk);
	endtask

	task automatic drain();
		item_valid = 1'b0;
		wait (setpoint_expect.size() == 0);
		repeat (20) @(negedge clk);
	endtask

	task automatic reg_write(logic regsel, logic [31:0] value);
		drain();
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = (regsel == REG_RAMP_TIME) ? 3'd4 : 3'd0;
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (regsel == REG_MAX_VELOCITY) cfg_max_vel = value & 32'h7fff_ffff;
		else cfg_ramp = value & 32'h7fff_ffff;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	function automatic logic [31:0] spread_value();
		return $urandom() >> $urandom_range(31);
	endfunction

	// one goal followed by updates swept across the planned profile
	task automatic run_move(logic signed [31:0] goal, logic signed [31:0] cur, int n_upd);
		bit [63:0] t, span;
		send_item(ACT_SET_GOAL, $urandom_range(3) == 0 ? $urandom() : 0, goal, cur);
		span = total_q == U32_ALL ? 64'd400000 : total_q + total_q / 4 + 2;
		if (span > U32_ALL) span = U32_ALL;
		t = 0;
		for (int i = 0; i < n_upd; i++) begin
			t += $urandom_range(0, 32'(span / n_upd) * 2 + 1);
			if (t > U32_ALL) t = U32_ALL;
			if ($urandom_range(9) == 0) send_item(ACT_UPDATE, $urandom(), $urandom(), $urandom());
			else send_item(ACT_UPDATE, t[31:0], $urandom(), $urandom());
		end
	endtask

	task automatic test_default_trapezoid();
		logic [31:0] upd_times[10] = '{0, 32768, 65536, 98304, 196608, 327680, 360448,
			393216, 458752, 131072};
		send_item(ACT_SET_GOAL, 0, 32'sd5 * 65536, 0);
		foreach (upd_times[i])
			send_item(ACT_UPDATE, upd_times[i], 0, 0);
		send_item(ACT_SET_GOAL, 32'h8000, -32'sd65536, 32'sd65536);
		send_item(ACT_UPDATE, 32'h10000, 0, 0);
		send_item(ACT_UPDATE, 32'h30000, 0, 0);
	endtask

	task automatic test_field_extremes();
		send_item(ACT_SET_GOAL, 32'hffff_ffff, 32'sh7fff_ffff, 32'sh8000_0000);
		send_item(ACT_UPDATE, 32'h0001_0000, 0, 0);
		send_item(ACT_UPDATE, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
		send_item(ACT_SET_GOAL, 0, 32'sh8000_0000, 32'sh7fff_ffff);
		send_item(ACT_UPDATE, 32'h7fff_ffff, 0, 0);
		send_item(ACT_SET_GOAL, 0, 32'sd77, 32'sd77);
		send_item(ACT_UPDATE, 32'h100, 0, 0);
	endtask

	task automatic test_register_extremes();
		reg_write(REG_MAX_VELOCITY, 32'h7fff_ffff);
		reg_write(REG_RAMP_TIME, 32'd1);
		run_move(32'sh4000_0000, 0, 4);
		reg_write(REG_MAX_VELOCITY, 32'hffff_ffff);
		reg_write(REG_RAMP_TIME, 32'hffff_ffff);
		run_move(32'sh0100_0000, 32'sh8000_0000, 4);
		reg_write(REG_RAMP_TIME, 32'd0);
		run_move(-32'sd1000, 0, 3);
		reg_write(REG_MAX_VELOCITY, 32'd0);
		run_move(32'sd1000, 0, 3);
		reg_write(REG_MAX_VELOCITY, 32'd1);
		reg_write(REG_RAMP_TIME, 32'h7fff_ffff);
		run_move(32'sd65536, 0, 3);
	endtask

	task automatic test_random_moves();
		int sent = 0;
		int n;
		logic signed [31:0] cur;
		while (sent < 560) begin
			if ($urandom_range(5) == 0) begin
				reg_write(REG_MAX_VELOCITY, $urandom_range(7) == 0 ? $urandom() : spread_value());
				reg_write(REG_RAMP_TIME, $urandom_range(7) == 0 ? $urandom() : spread_value());
			end
			if (sent >= 200 && sent < 320) quiet = 1'b1;
			else quiet = 1'b0;
			if (sent > 400 && sent < 420) drain();
			n = $urandom_range(2, 12);
			cur = $urandom();
			if ($urandom_range(3) == 0)
				run_move($urandom(), cur, n);
			else
				run_move(cur + (32'($signed(spread_value())) >>> $urandom_range(1)), cur, n);
			sent += n + 1;
		end
		quiet = 1'b0;
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);
		test_default_trapezoid();
		test_field_extremes();
		test_register_extremes();
		test_random_moves();
		item_valid = 1'b0;
		wait (setpoint_expect.size() == 0);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
